// File: hdl/fct_pkg.sv
// fct_pkg: shared types, constants and action codes for the frustum test
// no dependencies
package fct_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_SPHERE = 2'd1,
    ACT_BOX    = 2'd2,
    ACT_COLUMN = 2'd3
  } action_t;

  // coordinates carry 9 fraction bits; 27 bits covers all corner values
  localparam int CRD_W  = 27;
  // product of q2.14 by crd (27) is 43 bits
  localparam int PROD_W = 43;
  // sum of three products plus scaled d
  localparam int DIST_W = 46;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
  } plane_t;

  function automatic plane_t unpack_plane(input logic [63:0] r);
    plane_t p;
    p.a = r[15:0];
    p.b = r[31:16];
    p.c = r[47:32];
    p.d = r[63:48];
    return p;
  endfunction

endpackage

// File: hdl/frustum_containment_test.sv
// frustum_containment_test: top level, plane registers, corner setup and pipeline
// depends on fct_pkg and fct_plane
//
//  channel  signals                          direction
//  in       in_valid/in_ready, query fields  to block
//  out      out_valid/out_ready, inside_res  from block
//  cfg      cfg_valid/cfg_ready, index, data to block
//
// one word per cycle if not stalled; stages setup, product, sum, compare, combine
// all plane tests run in parallel lanes, one per plane
// rst clears planes to zero and all valid bits
// the whole pipeline advances when the output register is empty or taken
module frustum_containment_test import fct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic signed [23:0]   pos_x,
  input  logic signed [23:0]   pos_y,
  input  logic signed [23:0]   pos_z,
  input  logic [22:0]          extent,
  input  logic signed [15:0]   base_level,
  input  logic [14:0]          level_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 inside_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int DEPTH = 5;

  logic [63:0] planes [PLANE_COUNT];
  logic [DEPTH-1:0] vld;
  logic en;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[DEPTH-1];

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) planes[i] <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(PLANE_COUNT)) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // stage 0: corner coordinates and threshold
  logic signed [CRD_W-1:0]  xlo, xhi, ylo, yhi, zlo, zhi;
  logic signed [DIST_W-1:0] thr;
  logic [1:0]               act0;
  logic signed [CRD_W-1:0]  x2, y2, z2, e2, e1, bl, bh;
  always_comb begin
    x2 = CRD_W'(pos_x) <<< 1;
    y2 = CRD_W'(pos_y) <<< 1;
    z2 = CRD_W'(pos_z) <<< 1;
    e1 = CRD_W'({1'b0, extent});
    e2 = e1 <<< 1;
    bl = CRD_W'(base_level) <<< 9;
    bh = (CRD_W'(base_level) + CRD_W'({1'b0, level_count})) <<< 9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act0 <= action;
      thr  <= (action == ACT_SPHERE) ? (DIST_W'({1'b0, extent}) <<< 15) : '0;
      unique case (action)
        ACT_POINT, ACT_SPHERE: begin
          xlo <= x2; xhi <= x2; ylo <= y2; yhi <= y2; zlo <= z2; zhi <= z2;
        end
        ACT_BOX: begin
          xlo <= x2 - e2; xhi <= x2 + e2; ylo <= y2 - e1; yhi <= y2 + e1;
          zlo <= z2 - e2; zhi <= z2 + e2;
        end
        default: begin
          xlo <= x2 - e2; xhi <= x2 + e2; ylo <= bl; yhi <= bh;
          zlo <= z2 - e2; zhi <= z2 + e2;
        end
      endcase
    end
  end

  // one lane per plane
  logic [PLANE_COUNT-1:0] rej;
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    fct_plane u_plane (
      .clk(clk), .en(en), .pl(unpack_plane(planes[p])), .act(act0),
      .xlo(xlo), .xhi(xhi), .ylo(ylo), .yhi(yhi), .zlo(zlo), .zhi(zhi),
      .thr(thr), .reject(rej[p])
    );
  end

  // combine lanes into the output register
  always_ff @(posedge clk) begin
    if (en) inside_res <= !(|rej);
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost");
`endif

endmodule

// File: hdl/fct_plane.sv
// fct_plane: three-stage distance test of one plane against the corner set
// depends on fct_pkg
module fct_plane import fct_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  plane_t                  pl,
  input  logic [1:0]              act,
  input  logic signed [CRD_W-1:0] xlo,
  input  logic signed [CRD_W-1:0] xhi,
  input  logic signed [CRD_W-1:0] ylo,
  input  logic signed [CRD_W-1:0] yhi,
  input  logic signed [CRD_W-1:0] zlo,
  input  logic signed [CRD_W-1:0] zhi,
  input  logic signed [DIST_W-1:0] thr,
  output logic                    reject
);

  // stage 1: six products
  logic signed [PROD_W-1:0] pxl, pxh, pyl, pyh, pzl, pzh;
  logic signed [DIST_W-1:0] dsc, thr1;
  logic [1:0]               act1;
  always_ff @(posedge clk) begin
    if (en) begin
      pxl  <= PROD_W'(pl.a) * PROD_W'(xlo);
      pxh  <= PROD_W'(pl.a) * PROD_W'(xhi);
      pyl  <= PROD_W'(pl.b) * PROD_W'(ylo);
      pyh  <= PROD_W'(pl.b) * PROD_W'(yhi);
      pzl  <= PROD_W'(pl.c) * PROD_W'(zlo);
      pzh  <= PROD_W'(pl.c) * PROD_W'(zhi);
      dsc  <= DIST_W'(pl.d) <<< 19;
      thr1 <= thr;
      act1 <= act;
    end
  end

  // stage 2: partial sums x+d and y+z (four y/z combinations)
  logic signed [DIST_W-1:0] sxl, sxh, s00, s01, s10, s11, thr2;
  logic [1:0]               act2;
  always_ff @(posedge clk) begin
    if (en) begin
      sxl  <= DIST_W'(pxl) + dsc;
      sxh  <= DIST_W'(pxh) + dsc;
      s00  <= DIST_W'(pyl) + DIST_W'(pzl);
      s01  <= DIST_W'(pyh) + DIST_W'(pzl);
      s10  <= DIST_W'(pyl) + DIST_W'(pzh);
      s11  <= DIST_W'(pyh) + DIST_W'(pzh);
      thr2 <= thr1;
      act2 <= act1;
    end
  end

  // stage 3: eight corner distances against the threshold
  logic signed [DIST_W-1:0] cdist [8];
  logic [7:0]               above;
  always_comb begin
    cdist[0] = sxl + s00;
    cdist[1] = sxh + s00;
    cdist[2] = sxl + s01;
    cdist[3] = sxh + s01;
    cdist[4] = sxl + s10;
    cdist[5] = sxh + s10;
    cdist[6] = sxl + s11;
    cdist[7] = sxh + s11;
    for (int i = 0; i < 8; i++) above[i] = cdist[i] > thr2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (act2 == ACT_POINT || act2 == ACT_SPHERE) reject <= !above[0];
      else reject <= !(|above);
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for frustum_containment_test, directed table then random queries
// depends on fct_pkg and the frustum_containment_test rtl
module tb;
  import fct_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int RAND_ITEMS   = 1930;

  // plane set kinds used by the phases
  typedef enum int {SET_ZERO, SET_OPEN, SET_AXIS, SET_RANDOM, SET_ONES, SET_MINNEG} plane_set_t;

  typedef struct {
    action_t            act;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [22:0]        e;
    logic signed [15:0] base;
    logic [14:0]        cnt;
  } query_t;

  typedef struct {
    plane_set_t set;
    query_t     q;
    bit         typed;
    bit         res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] action = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [22:0] extent = '0;
  logic signed [15:0] base_level = '0;
  logic [14:0] level_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic inside_res;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] plane_regs[PLANE_COUNT];
  bit inside_q[$];
  row_t rows[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_inside = 0;
  bit hold_req = 0;

  frustum_containment_test dut (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("frustum_containment_test test failed");
      $finish;
    end
  end

  // signed distance with 23 fraction bits
  function automatic longint plane_dist(int p, longint x2, longint y2, longint z2);
    longint a, b, c, d;
    a = longint'($signed(plane_regs[p][15:0]));
    b = longint'($signed(plane_regs[p][31:16]));
    c = longint'($signed(plane_regs[p][47:32]));
    d = longint'($signed(plane_regs[p][63:48]));
    return a * x2 + b * y2 + c * z2 + d * 524288;
  endfunction

  function automatic bit corners_out(int p, longint x2, longint z2, longint s2,
                                     longint ylo, longint yhi);
    for (int iz = 0; iz < 2; iz++)
      for (int iy = 0; iy < 2; iy++)
        for (int ix = 0; ix < 2; ix++)
          if (plane_dist(p, ix ? x2 + s2 : x2 - s2, iy ? yhi : ylo,
                         iz ? z2 + s2 : z2 - s2) > 0)
            return 0;
    return 1;
  endfunction

  function automatic bit predict_inside(query_t q);
    longint x2, y2, z2, e, base, cnt;
    bit rej;
    x2 = longint'(q.x) * 2;
    y2 = longint'(q.y) * 2;
    z2 = longint'(q.z) * 2;
    e = longint'({41'd0, q.e});
    base = longint'(q.base);
    cnt = longint'({49'd0, q.cnt});
    for (int p = 0; p < PLANE_COUNT; p++) begin
      case (q.act)
        ACT_POINT:  rej = plane_dist(p, x2, y2, z2) <= 0;
        ACT_SPHERE: rej = plane_dist(p, x2, y2, z2) <= e * 32768;
        ACT_BOX:    rej = corners_out(p, x2, z2, e * 2, y2 - e, y2 + e);
        default:    rej = corners_out(p, x2, z2, e * 2, base * 512, (base + cnt) * 512);
      endcase
      if (rej) return 0;
    end
    return 1;
  endfunction

  function automatic logic [63:0] pack_plane(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 512)) - 256;
  endfunction

  // wait for every expected word, then let the pipeline empty
  task automatic wait_drain();
    while (inside_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all plane registers back to back, one extra unused index now and then
  task automatic load_planes(plane_set_t set);
    logic [63:0] v[PLANE_COUNT + 1];
    int r, n;
    r = $urandom_range(1, 1500) * 16;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      case (set)
        SET_ZERO:   v[i] = '0;
        SET_OPEN:   v[i] = pack_plane(0, 0, 0, 32767);
        SET_ONES:   v[i] = '1;
        SET_MINNEG: v[i] = pack_plane(-32768, -32768, -32768, -32768);
        SET_RANDOM: v[i] = {$urandom, $urandom};
        default: begin
          // axis-aligned box around the origin with tilted normals
          case (i)
            0: v[i] = pack_plane(-16384, jitter(), jitter(), r + jitter());
            1: v[i] = pack_plane(16384, jitter(), jitter(), r + jitter());
            2: v[i] = pack_plane(jitter(), 16384, jitter(), r + jitter());
            3: v[i] = pack_plane(jitter(), -16384, jitter(), r + jitter());
            4: v[i] = pack_plane(jitter(), jitter(), 16384, r + jitter());
            default: v[i] = pack_plane(jitter(), jitter(), -16384, r + jitter());
          endcase
        end
      endcase
    end
    v[PLANE_COUNT] = {$urandom, $urandom};
    n = ($urandom_range(0, 3) == 0) ? PLANE_COUNT + 1 : PLANE_COUNT;
    cfg_valid <= 1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= (i == PLANE_COUNT) ? CFG_IDX_W'($urandom_range(PLANE_COUNT, 7))
                                      : CFG_IDX_W'(i);
      cfg_data <= v[i];
      do @(posedge clk); while (!cfg_ready);
      if (i < PLANE_COUNT) plane_regs[i] = v[i];
    end
    cfg_valid <= 0;
  endtask

  // offer one query word, expected value recorded at acceptance
  task automatic send_query(query_t q, bit typed, bit res);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    action <= q.act;
    pos_x <= q.x;
    pos_y <= q.y;
    pos_z <= q.z;
    extent <= q.e;
    base_level <= q.base;
    level_count <= q.cnt;
    do @(posedge clk); while (!in_ready);
    inside_q.push_back(typed ? res : predict_inside(q));
    n_sent++;
  endtask

  function automatic query_t rand_query(int span);
    query_t q;
    q.act = action_t'($urandom_range(0, 3));
    if ($urandom_range(0, 6) == 0) begin
      // full range noise
      q.x = 24'($urandom); q.y = 24'($urandom); q.z = 24'($urandom);
      q.e = 23'($urandom); q.base = 16'($urandom); q.cnt = 15'($urandom);
    end else begin
      q.x = 24'(int'($urandom_range(0, 2 * span)) - span);
      q.y = 24'(int'($urandom_range(0, 2 * span)) - span);
      q.z = 24'(int'($urandom_range(0, 2 * span)) - span);
      q.e = 23'($urandom_range(0, span / 3));
      q.base = 16'(int'($urandom_range(0, 2 * (span >> 8))) - (span >> 8));
      q.cnt = 15'($urandom_range(0, span >> 7));
    end
    return q;
  endfunction

  function automatic void add_row(plane_set_t set, action_t act, int x, int y, int z,
                                  int e, int base, int cnt, bit typed, bit res);
    row_t r;
    r.set = set; r.typed = typed; r.res = res;
    r.q.act = act; r.q.x = 24'(x); r.q.y = 24'(y); r.q.z = 24'(z);
    r.q.e = 23'(e); r.q.base = 16'(base); r.q.cnt = 15'(cnt);
    rows.push_back(r);
  endfunction

  // result side: random stalls, one long hold on request
  initial begin
    bit exp_v;
    @(negedge rst);
    forever begin
      int stall;
      stall = $urandom_range(0, 5);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      if (inside_q.size() == 0) begin
        $display("%0t: unexpected word inside_res=%0b", $time, inside_res);
        errors++;
      end else begin
        exp_v = inside_q.pop_front();
        n_inside += exp_v;
        if (inside_res !== exp_v) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, exp_v, inside_res);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    plane_set_t cur;
    plane_set_t kinds[8];
    for (int i = 0; i < PLANE_COUNT; i++) plane_regs[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero planes after reset reject everything
    add_row(SET_ZERO, ACT_POINT, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(SET_ZERO, ACT_POINT, 8388607, 8388607, 8388607, 0, 0, 0, 1, 0);
    add_row(SET_ZERO, ACT_SPHERE, -8388608, -8388608, -8388608, 0, 0, 0, 1, 0);
    add_row(SET_ZERO, ACT_BOX, 0, 0, 0, 8388607, 0, 0, 1, 0);
    add_row(SET_ZERO, ACT_COLUMN, 0, 0, 0, 8388607, -32768, 32767, 1, 0);
    // open planes: distance is the positive offset everywhere
    add_row(SET_OPEN, ACT_POINT, 8388607, -8388608, 8388607, 0, 0, 0, 1, 1);
    add_row(SET_OPEN, ACT_POINT, -8388608, 8388607, -8388608, 8388607, 0, 0, 1, 1);
    add_row(SET_OPEN, ACT_SPHERE, 0, 0, 0, 0, 0, 0, 1, 1);
    add_row(SET_OPEN, ACT_SPHERE, 0, 0, 0, 8388607, 0, 0, 1, 0);
    add_row(SET_OPEN, ACT_BOX, 8388607, 8388607, 8388607, 8388607, 0, 0, 1, 1);
    add_row(SET_OPEN, ACT_COLUMN, -8388608, 0, -8388608, 8388607, -32768, 32767, 1, 1);
    add_row(SET_OPEN, ACT_COLUMN, 0, 0, 0, 0, 32767, 0, 1, 1);
    // axis box: predictor decides
    add_row(SET_AXIS, ACT_POINT, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_POINT, 8388607, 0, 0, 0, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_SPHERE, 2560, -2560, 256, 2560, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_SPHERE, 0, 0, 0, 8388607, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_BOX, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_BOX, -8388608, 8388607, -8388608, 8388607, 0, 0, 0, 0);
    add_row(SET_AXIS, ACT_COLUMN, 0, 8388607, 0, 256, -5, 10, 0, 0);
    add_row(SET_AXIS, ACT_COLUMN, 512000, 0, 512000, 1, -32768, 32767, 0, 0);

    cur = SET_ZERO;
    foreach (rows[i]) begin
      if (rows[i].set != cur) begin
        in_valid <= 0;
        wait_drain();
        load_planes(rows[i].set);
        cur = rows[i].set;
      end
      send_query(rows[i].q, rows[i].typed, rows[i].res);
    end

    // random phases over several plane sets
    kinds = '{SET_AXIS, SET_RANDOM, SET_AXIS, SET_ONES, SET_AXIS, SET_MINNEG, SET_OPEN, SET_AXIS};
    for (int ph = 0; ph < 8; ph++) begin
      int span;
      in_valid <= 0;
      wait_drain();
      load_planes(kinds[ph]);
      if (ph == 2) hold_req = 1;
      span = (kinds[ph] == SET_AXIS) ? 400000 : 8388607 / 2;
      for (int k = 0; k < RAND_ITEMS / 8; k++) send_query(rand_query(span), 0, 0);
    end
    in_valid <= 0;

    wait_drain();
    $display("sent %0d queries over zero, open, axis, random and extreme plane sets", n_sent);
    $display("%0d reported inside, one long output stall included", n_inside);
    if (errors == 0 && inside_q.size() == 0)
      $display("frustum_containment_test test passed");
    else
      $display("frustum_containment_test test failed");
    $finish;
  end
endmodule
